// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the stable priority queue.
// No dependencies; used by spq_cell and stable_priority_queue.
package spq_pkg;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // One stored task.
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] dur;
    } entry_t;

    // Row-wide control broadcast to every cell.
    typedef struct packed {
        logic upd;   // state changes this cycle
        logic ins;   // 1 insert, 0 remove
    } cell_ctl_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted task row.
// Depends on spq_pkg.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctl_t ctl,
    input  spq_pkg::entry_t    new_entry,
    input  logic               occupied,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               keep,
    output spq_pkg::entry_t    entry,
    output spq_pkg::entry_t    entry_next
);

    spq_pkg::entry_t entry_reg;

    // Stored task stays ahead of the newcomer on ties (arrival order).
    assign keep  = occupied && (entry_reg.prio >= new_entry.prio);
    assign entry = entry_reg;

    always_comb
    begin
        if (ctl.ins)
        begin
            if (keep)
                entry_next = entry_reg;
            else if (left_keep)
                entry_next = new_entry;
            else
                entry_next = left_entry;
        end
        else
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.upd)
            entry_reg <= entry_next;
    end

endmodule

// ----- rtl/core/stable_priority_queue.sv -----
`timescale 1ns / 1ps
// Stable priority queue: a row of QUEUE_DEPTH cells kept sorted, head in cell 0.
// An insert lands behind every stored task of greater or equal priority, so
// equal priorities leave in arrival order; a remove returns the head. Every
// request gives exactly one result carrying status, the removed task (if any),
// the new head and the occupancy. Each request is settled at once:
// all cells compare their priority with the new task in parallel and each one
// either holds, takes the new task, or takes its neighbor's task. A result
// register sits on the output, so one request per clock is taken while that
// register is empty or being drained; a stalled result holds off the next
// request. The result shows in the cycle after the request transfer.
// Occupancy is reported modulo 32. Depends on spq_pkg and spq_cell.
module stable_priority_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        req_valid,
    output logic        req_stall,
    input  logic        req_type,
    input  logic [15:0] task_id,
    input  logic [7:0]  task_priority,
    input  logic [15:0] task_duration,

    output logic        res_valid,
    input  logic        res_stall,
    output logic [1:0]  status,
    output logic        out_valid,
    output logic [15:0] out_task_id,
    output logic [7:0]  out_task_priority,
    output logic [15:0] out_task_duration,
    output logic        head_valid,
    output logic [15:0] head_task_id,
    output logic [7:0]  head_task_priority,
    output logic [4:0]  occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               res_valid_reg;
    spq_pkg::status_t   status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    spq_pkg::entry_t    out_entry_reg, out_entry_next;
    logic               head_valid_reg, head_valid_next;
    spq_pkg::entry_t    head_entry_reg, head_entry_next;
    logic [4:0]         occupancy_reg, occupancy_next;

    logic               req_fire;
    logic               is_ins;
    logic               full;
    logic               empty;
    spq_pkg::cell_ctl_t ctl;
    spq_pkg::entry_t    new_entry;

    spq_pkg::entry_t    cell_q    [QUEUE_DEPTH];
    spq_pkg::entry_t    cell_next [QUEUE_DEPTH];
    logic               cell_keep [QUEUE_DEPTH];

    assign req_stall = res_valid_reg && res_stall;
    assign req_fire  = req_valid && !req_stall;
    assign is_ins    = (req_type == spq_pkg::REQ_INSERT);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);

    assign new_entry.id   = task_id;
    assign new_entry.prio = task_priority;
    assign new_entry.dur  = task_duration;

    // A full insert or an empty remove leaves the row alone.
    assign ctl.ins = is_ins;
    assign ctl.upd = req_fire && (is_ins ? !full : !empty);

    // Cell row: left neighbor feeds inserts, right neighbor feeds removes.
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            spq_pkg::entry_t lft_entry;
            spq_pkg::entry_t rgt_entry;
            logic            lft_keep;

            if (gi == 0)
            begin : g_first
                assign lft_keep  = 1'b1;
                assign lft_entry = new_entry;
            end
            else
            begin : g_mid
                assign lft_keep  = cell_keep[gi-1];
                assign lft_entry = cell_q[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign rgt_entry = cell_q[gi];
            end
            else
            begin : g_inner
                assign rgt_entry = cell_q[gi+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .occupied   (count_reg > CNT_W'(gi)),
                .left_keep  (lft_keep),
                .left_entry (lft_entry),
                .right_entry(rgt_entry),
                .keep       (cell_keep[gi]),
                .entry      (cell_q[gi]),
                .entry_next (cell_next[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (ctl.upd)
        begin
            if (is_ins)
                count_next = count_reg + CNT_W'(1);
            else
                count_next = count_reg - CNT_W'(1);
        end
    end

    // Result for the request being transferred.
    always_comb
    begin
        status_next    = spq_pkg::STATUS_OK;
        out_valid_next = 1'b0;
        out_entry_next = '0;
        if (is_ins)
        begin
            if (full)
                status_next = spq_pkg::STATUS_FULL;
        end
        else if (empty)
        begin
            status_next = spq_pkg::STATUS_EMPTY;
        end
        else
        begin
            out_valid_next = 1'b1;
            out_entry_next = cell_q[0];
        end

        head_valid_next = (count_next != '0);
        head_entry_next = '0;
        if (head_valid_next)
            head_entry_next = ctl.upd ? cell_next[0] : cell_q[0];
        occupancy_next = 5'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (req_fire)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
            out_entry_reg  <= out_entry_next;
            head_valid_reg <= head_valid_next;
            head_entry_reg <= head_entry_next;
            occupancy_reg  <= occupancy_next;
        end
    end

    assign res_valid          = res_valid_reg;
    assign status             = status_reg;
    assign out_valid          = out_valid_reg;
    assign out_task_id        = out_entry_reg.id;
    assign out_task_priority  = out_entry_reg.prio;
    assign out_task_duration  = out_entry_reg.dur;
    assign head_valid         = head_valid_reg;
    assign head_task_id       = head_entry_reg.id;
    assign head_task_priority = head_entry_reg.prio;
    assign occupancy          = occupancy_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.upd && is_ins) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the queue");

    a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (head_valid_reg == (count_reg != '0)))
        else $error("head flag disagrees with occupancy");

    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg >= CNT_W'(2)) |-> (cell_q[0].prio >= cell_q[1].prio))
        else $error("head out of priority order");
`endif

endmodule
